/* hdl/rcstv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rcstv_pkg;

   // field and register widths
   localparam int CH_W      = 16;
   localparam int SPEED_W   = 16;
   localparam int LIMIT_W   = 5;
   localparam int DB_W      = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int NUM_LANE  = 3;

   // stream payload widths, data padded to whole bytes
   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 2;

   // parameter defaults
   localparam int DEFAULT_STICK_SPAN          = 500;
   localparam int DEFAULT_SPEED_FRACTION_BITS = 10;

   // fixed channel limits and switch positions
   localparam logic [CH_W-1:0] CH_MIN      = 16'd900;
   localparam logic [CH_W-1:0] CH_MAX      = 16'd2100;
   localparam logic [CH_W-1:0] SW_FAST_POS = 16'd2000;
   localparam logic [CH_W-1:0] SW_SLOW_POS = 16'd1000;
   localparam int              SPEED_CAP   = 20;

   // register reset values
   localparam logic [CH_W-1:0]    RST_STICK_CENTER     = 16'd1500;
   localparam logic [DB_W-1:0]    RST_DEADBAND         = 10'd30;
   localparam logic [DB_W-1:0]    RST_SWITCH_TOLERANCE = 10'd250;
   localparam logic [CH_W-1:0]    RST_ENABLE_THRESHOLD = 16'd1200;
   localparam logic [LIMIT_W-1:0] RST_FAST_LIMIT       = 5'd20;
   localparam logic [LIMIT_W-1:0] RST_MEDIUM_LIMIT     = 5'd10;
   localparam logic [LIMIT_W-1:0] RST_SLOW_LIMIT       = 5'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STICK_CENTER     = 3'd0,
      REG_DEADBAND         = 3'd1,
      REG_SWITCH_TOLERANCE = 3'd2,
      REG_ENABLE_THRESHOLD = 3'd3,
      REG_FAST_LIMIT       = 3'd4,
      REG_MEDIUM_LIMIT     = 3'd5,
      REG_SLOW_LIMIT       = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      LEVEL_SLOW   = 2'd0,
      LEVEL_MEDIUM = 2'd1,
      LEVEL_FAST   = 2'd2
   } speed_level_type;

   typedef struct packed {
      logic            online;
      logic            enabled;
      speed_level_type level;
   } ctl_type;

endpackage

`default_nettype wire

/* hdl/rc_stick_to_velocity_command.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+-------------------------------------------
// req       | in        | req_tvalid/req_tready | one receiver frame (sticks, switch, knob)
// rsp       | out       | rsp_tvalid/rsp_tready | flags, speed level, three speed commands
// csr       | in        | csr_we                | register index and write data, no read-back
//
// one item per clock sustained while rsp_tready stays high
// the divide by stick span is done as two reciprocal
// multiply and correct steps, each a multiplier stage and a fix-up stage
// reset (synchronous) empties the pipe and restores the register defaults
// every stage holds while its successor is full and holding; ready ripples back so
// bubbles are squeezed out and a waiting result holds the input only once
// every stage is full

module rc_stick_to_velocity_command
   import rcstv_pkg::*;
#(
   parameter int STICK_SPAN          = DEFAULT_STICK_SPAN,
   parameter int SPEED_FRACTION_BITS = DEFAULT_SPEED_FRACTION_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // right_y_channel, right_x_channel, left_x_channel, switch_channel, enable_channel
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // receiver_valid
   input  wire logic [REQ_USER_W-1:0] req_tuser,

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // speed_level, forward_speed, lateral_speed, yaw_rate, zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // online flag, enabled flag
   output logic [RSP_USER_W-1:0]      rsp_tuser,

   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NSTAGE = 8;
   localparam int FB     = SPEED_FRACTION_BITS;
   localparam int DIFF_W = CH_W + 1;
   localparam int MAG_W  = $clog2(STICK_SPAN + 1);  // clamped stick offset
   localparam int P_W    = MAG_W + LIMIT_W;         // offset times limit
   localparam int XB_W   = MAG_W + FB;              // remainder shifted by fraction bits
   localparam int SPD_W  = LIMIT_W + FB;            // speed magnitude
   localparam int MA_W   = P_W + 1;
   localparam int MB_W   = XB_W + 1;
   localparam int PAD_W  = RSP_DATA_W - 2 - NUM_LANE * SPEED_W;

   // floor(2^W / span): the estimate is at most one short of the quotient
   localparam logic [MA_W-1:0]  RECIP_A = MA_W'((64'd1 << P_W) / STICK_SPAN);
   localparam logic [MB_W-1:0]  RECIP_B = MB_W'((64'd1 << XB_W) / STICK_SPAN);
   localparam logic [MAG_W-1:0] SPAN_M  = MAG_W'(STICK_SPAN);
   localparam logic [CH_W-1:0]  SPAN_CH = CH_W'(STICK_SPAN);
   localparam logic [SPD_W-1:0] CAP_M   = SPD_W'(SPEED_CAP << FB);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [CH_W-1:0]    center_ff;
   logic [DB_W-1:0]    deadband_ff;
   logic [DB_W-1:0]    tolerance_ff;
   logic [CH_W-1:0]    threshold_ff;
   logic [LIMIT_W-1:0] fast_limit_ff;
   logic [LIMIT_W-1:0] medium_limit_ff;
   logic [LIMIT_W-1:0] slow_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff       <= RST_STICK_CENTER;
         deadband_ff     <= RST_DEADBAND;
         tolerance_ff    <= RST_SWITCH_TOLERANCE;
         threshold_ff    <= RST_ENABLE_THRESHOLD;
         fast_limit_ff   <= RST_FAST_LIMIT;
         medium_limit_ff <= RST_MEDIUM_LIMIT;
         slow_limit_ff   <= RST_SLOW_LIMIT;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_STICK_CENTER:     center_ff       <= csr_wdata[CH_W-1:0];
            REG_DEADBAND:         deadband_ff     <= csr_wdata[DB_W-1:0];
            REG_SWITCH_TOLERANCE: tolerance_ff    <= csr_wdata[DB_W-1:0];
            REG_ENABLE_THRESHOLD: threshold_ff    <= csr_wdata[CH_W-1:0];
            REG_FAST_LIMIT:       fast_limit_ff   <= csr_wdata[LIMIT_W-1:0];
            REG_MEDIUM_LIMIT:     medium_limit_ff <= csr_wdata[LIMIT_W-1:0];
            REG_SLOW_LIMIT:       slow_limit_ff   <= csr_wdata[LIMIT_W-1:0];
            default: ;  // index beyond the register list is dropped
         endcase
      end
   end

   // ------------------------------------------------------------------
   // pipeline flow control: stage k loads when empty or when k+1 loads
   // ------------------------------------------------------------------
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] rdy;
   logic [NSTAGE-1:0] vld_src;

   always_comb begin
      rdy[NSTAGE-1] = !vld_ff[NSTAGE-1] || rsp_tready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign vld_src    = {vld_ff[NSTAGE-2:0], req_tvalid};
   assign req_tready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_src[k];
         end
      end
   end

   // control flags, lane zero marks and lane signs travel down the pipe
   ctl_type             ctl_ff  [NSTAGE];
   logic [NUM_LANE-1:0] zero_ff [NSTAGE-1];
   logic [NUM_LANE-1:0] neg_ff  [NSTAGE-1];

   // ------------------------------------------------------------------
   // stage 0: unpack, range checks, offset from centre, speed switch
   // ------------------------------------------------------------------
   logic [CH_W-1:0]          chan [NUM_LANE];
   logic [CH_W-1:0]          sw_chan;
   logic [CH_W-1:0]          en_chan;
   logic [CH_W-1:0]          fast_dist;
   logic [CH_W-1:0]          slow_dist;
   ctl_type                  ctl_s0_in;
   logic [LIMIT_W-1:0]       limit_s0_in;
   logic [NUM_LANE-1:0]      zero_s0_in;
   logic [NUM_LANE-1:0]      neg_s0_in;
   logic signed [DIFF_W-1:0] diff_s0_in [NUM_LANE];
   logic signed [DIFF_W-1:0] diff_s0_ff [NUM_LANE];
   logic [LIMIT_W-1:0]       limit_s0_ff;

   assign chan[0] = req_tdata[15:0];   // forward
   assign chan[1] = req_tdata[31:16];  // lateral
   assign chan[2] = req_tdata[47:32];  // yaw
   assign sw_chan = req_tdata[63:48];
   assign en_chan = req_tdata[79:64];

   always_comb begin
      fast_dist = (sw_chan > SW_FAST_POS) ? sw_chan - SW_FAST_POS : SW_FAST_POS - sw_chan;
      slow_dist = (sw_chan > SW_SLOW_POS) ? sw_chan - SW_SLOW_POS : SW_SLOW_POS - sw_chan;

      ctl_s0_in.online  = req_tuser[0];
      ctl_s0_in.enabled = req_tuser[0] && (en_chan <= threshold_ff);

      // fast position is tested first and wins where both match
      if (fast_dist <= CH_W'(tolerance_ff)) begin
         ctl_s0_in.level = LEVEL_FAST;
         limit_s0_in     = fast_limit_ff;
      end else if (slow_dist <= CH_W'(tolerance_ff)) begin
         ctl_s0_in.level = LEVEL_SLOW;
         limit_s0_in     = slow_limit_ff;
      end else begin
         ctl_s0_in.level = LEVEL_MEDIUM;
         limit_s0_in     = medium_limit_ff;
      end
      if (!ctl_s0_in.enabled) ctl_s0_in.level = LEVEL_SLOW;

      for (int l = 0; l < NUM_LANE; l++) begin
         diff_s0_in[l] = $signed({1'b0, chan[l]}) - $signed({1'b0, center_ff});
         neg_s0_in[l]  = diff_s0_in[l][DIFF_W-1];
         zero_s0_in[l] = (chan[l] < CH_MIN) || (chan[l] > CH_MAX) || !ctl_s0_in.enabled;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: magnitude, deadband, clamp to span
   // ------------------------------------------------------------------
   logic [CH_W-1:0]     abs_s1 [NUM_LANE];
   logic [NUM_LANE-1:0] zero_s1_in;
   logic [MAG_W-1:0]    mag_s1_in [NUM_LANE];
   logic [MAG_W-1:0]    mag_s1_ff [NUM_LANE];
   logic [LIMIT_W-1:0]  limit_s1_ff;

   always_comb begin
      for (int l = 0; l < NUM_LANE; l++) begin
         abs_s1[l] = neg_ff[0][l] ? CH_W'(-diff_s0_ff[l]) : CH_W'(diff_s0_ff[l]);
         zero_s1_in[l] = zero_ff[0][l] || (abs_s1[l] <= CH_W'(deadband_ff));
         mag_s1_in[l]  = (abs_s1[l] > SPAN_CH) ? SPAN_M : MAG_W'(abs_s1[l]);
      end
   end

   // ------------------------------------------------------------------
   // stage 2: offset times selected limit
   // ------------------------------------------------------------------
   logic [P_W-1:0] prod_s2_in [NUM_LANE];
   logic [P_W-1:0] prod_s2_ff [NUM_LANE];

   always_comb begin
      for (int l = 0; l < NUM_LANE; l++) begin
         prod_s2_in[l] = P_W'(mag_s1_ff[l]) * P_W'(limit_s1_ff);
      end
   end

   // ------------------------------------------------------------------
   // stage 3: whole part of product / span, reciprocal estimate
   // ------------------------------------------------------------------
   logic [P_W+MA_W-1:0] recip_a    [NUM_LANE];
   logic [LIMIT_W-1:0]  qa0_s3_in  [NUM_LANE];
   logic [LIMIT_W-1:0]  qa0_s3_ff  [NUM_LANE];
   logic [P_W-1:0]      prod_s3_ff [NUM_LANE];

   always_comb begin
      for (int l = 0; l < NUM_LANE; l++) begin
         recip_a[l]   = (P_W+MA_W)'(prod_s2_ff[l]) * (P_W+MA_W)'(RECIP_A);
         qa0_s3_in[l] = recip_a[l][P_W +: LIMIT_W];
      end
   end

   // ------------------------------------------------------------------
   // stage 4: correct the whole part, keep the remainder
   // ------------------------------------------------------------------
   logic [P_W:0]         rem_a     [NUM_LANE];
   logic [LIMIT_W-1:0]   qa_s4_in  [NUM_LANE];
   logic [MAG_W-1:0]     ra_s4_in  [NUM_LANE];
   logic [LIMIT_W-1:0]   qa_s4_ff  [NUM_LANE];
   logic [MAG_W-1:0]     ra_s4_ff  [NUM_LANE];

   always_comb begin
      for (int l = 0; l < NUM_LANE; l++) begin
         rem_a[l] = {1'b0, prod_s3_ff[l]} - (P_W+1)'(qa0_s3_ff[l]) * (P_W+1)'(SPAN_M);
         if (rem_a[l] >= (P_W+1)'(SPAN_M)) begin
            qa_s4_in[l] = qa0_s3_ff[l] + 1'b1;
            ra_s4_in[l] = MAG_W'(rem_a[l] - (P_W+1)'(SPAN_M));
         end else begin
            qa_s4_in[l] = qa0_s3_ff[l];
            ra_s4_in[l] = MAG_W'(rem_a[l]);
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 5: fraction bits, (remainder << fb) / span estimate
   // ------------------------------------------------------------------
   logic [XB_W+MB_W-1:0] recip_b   [NUM_LANE];
   logic [FB-1:0]        qb0_s5_in [NUM_LANE];
   logic [FB-1:0]        qb0_s5_ff [NUM_LANE];
   logic [LIMIT_W-1:0]   qa_s5_ff  [NUM_LANE];
   logic [MAG_W-1:0]     ra_s5_ff  [NUM_LANE];

   always_comb begin
      for (int l = 0; l < NUM_LANE; l++) begin
         recip_b[l]   = (XB_W+MB_W)'({ra_s4_ff[l], {FB{1'b0}}}) * (XB_W+MB_W)'(RECIP_B);
         qb0_s5_in[l] = recip_b[l][XB_W +: FB];
      end
   end

   // ------------------------------------------------------------------
   // stage 6: correct the fraction bits and join with the whole part
   // ------------------------------------------------------------------
   logic [XB_W:0]      rem_b     [NUM_LANE];
   logic [FB-1:0]      qb_s6     [NUM_LANE];
   logic [SPD_W-1:0]   mag_s6_in [NUM_LANE];
   logic [SPD_W-1:0]   mag_s6_ff [NUM_LANE];

   always_comb begin
      for (int l = 0; l < NUM_LANE; l++) begin
         rem_b[l] = (XB_W+1)'({ra_s5_ff[l], {FB{1'b0}}})
                    - (XB_W+1)'(qb0_s5_ff[l]) * (XB_W+1)'(SPAN_M);
         qb_s6[l] = (rem_b[l] >= (XB_W+1)'(SPAN_M)) ? qb0_s5_ff[l] + 1'b1 : qb0_s5_ff[l];
         mag_s6_in[l] = {qa_s5_ff[l], qb_s6[l]};
      end
   end

   // ------------------------------------------------------------------
   // stage 7: cap, negate, zero where the lane is dead
   // ------------------------------------------------------------------
   logic [SPD_W-1:0]          cap_s7      [NUM_LANE];
   logic signed [SPD_W:0]     sgn_s7      [NUM_LANE];
   logic signed [SPEED_W-1:0] speed_s7_in [NUM_LANE];
   logic signed [SPEED_W-1:0] speed_s7_ff [NUM_LANE];

   always_comb begin
      for (int l = 0; l < NUM_LANE; l++) begin
         cap_s7[l] = (mag_s6_ff[l] > CAP_M) ? CAP_M : mag_s6_ff[l];
         // the command is the negated stick speed
         sgn_s7[l] = neg_ff[NSTAGE-2][l] ? $signed({1'b0, cap_s7[l]})
                                         : -$signed({1'b0, cap_s7[l]});
         speed_s7_in[l] = zero_ff[NSTAGE-2][l] ? '0 : SPEED_W'(sgn_s7[l]);
      end
   end

   // ------------------------------------------------------------------
   // pipeline registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         ctl_ff[0]   <= ctl_s0_in;
         zero_ff[0]  <= zero_s0_in;
         neg_ff[0]   <= neg_s0_in;
         limit_s0_ff <= limit_s0_in;
         diff_s0_ff  <= diff_s0_in;
      end
      for (int k = 1; k < NSTAGE; k++) begin
         if (rdy[k]) ctl_ff[k] <= ctl_ff[k-1];
      end
      for (int k = 2; k < NSTAGE - 1; k++) begin
         if (rdy[k]) begin
            zero_ff[k] <= zero_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
         end
      end
      if (rdy[1]) begin
         zero_ff[1]  <= zero_s1_in;
         neg_ff[1]   <= neg_ff[0];
         mag_s1_ff   <= mag_s1_in;
         limit_s1_ff <= limit_s0_ff;
      end
      if (rdy[2]) prod_s2_ff <= prod_s2_in;
      if (rdy[3]) begin
         qa0_s3_ff  <= qa0_s3_in;
         prod_s3_ff <= prod_s2_ff;
      end
      if (rdy[4]) begin
         qa_s4_ff <= qa_s4_in;
         ra_s4_ff <= ra_s4_in;
      end
      if (rdy[5]) begin
         qb0_s5_ff <= qb0_s5_in;
         qa_s5_ff  <= qa_s4_ff;
         ra_s5_ff  <= ra_s4_ff;
      end
      if (rdy[6]) mag_s6_ff <= mag_s6_in;
      if (rdy[7]) speed_s7_ff <= speed_s7_in;
   end

   // ------------------------------------------------------------------
   // result item
   // ------------------------------------------------------------------
   assign rsp_tvalid = vld_ff[NSTAGE-1];
   assign rsp_tuser  = {ctl_ff[NSTAGE-1].enabled, ctl_ff[NSTAGE-1].online};
   assign rsp_tdata  = {{PAD_W{1'b0}}, speed_s7_ff[2], speed_s7_ff[1], speed_s7_ff[0],
                        ctl_ff[NSTAGE-1].level};

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_enabled_needs_online: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("enabled result without online frame");

   a_disabled_is_still: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[RSP_DATA_W-1:0] == '0)
      else $error("speed or level set while motion disabled");

   a_level_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("unused speed level code on output");

   a_accept_fills_first: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted item missing from first stage");

endmodule

`default_nettype wire

/* sim/rc_stick_to_velocity_command_tb.sv */
`timescale 1ns / 1ps

module rc_stick_to_velocity_command_tb;
   import rcstv_pkg::*;

   // block parameters, kept at their defaults
   localparam int STICK_SPAN = DEFAULT_STICK_SPAN;
   localparam int FRAC_BITS  = DEFAULT_SPEED_FRACTION_BITS;
   localparam int SPEED_MAX  = SPEED_CAP << FRAC_BITS;

   // index past the register list, writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   // pipe is eight deep, settle a little longer than that
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_AT_FRAME  = 500;
   localparam int HOLD_CYCLES    = 200;
   localparam int NUM_PHASES     = 10;
   localparam int FIRST_RANDOM   = 85;
   localparam int PHASE_RANDOM   = 105;
   localparam int QUIET_PHASE    = 6;

   // one receiver frame as it goes into the block
   typedef struct packed {
      logic            valid;
      logic [CH_W-1:0] ry;
      logic [CH_W-1:0] rx;
      logic [CH_W-1:0] lx;
      logic [CH_W-1:0] sw;
      logic [CH_W-1:0] en;
   } frame_type;

   // one velocity command as it comes out
   typedef struct packed {
      logic                      online;
      logic                      enabled;
      speed_level_type           level;
      logic signed [SPEED_W-1:0] fwd;
      logic signed [SPEED_W-1:0] lat;
      logic signed [SPEED_W-1:0] yaw;
   } command_type;

   // directed row: a frame and, where it is obvious, the command typed in
   typedef struct packed {
      frame_type   frame;
      logic        typed;
      command_type want;
   } directed_row_type;

   localparam int NUM_DIRECTED = 18;

   // directed rows at reset defaults: centre 1500, deadband 30, tolerance 250,
   // threshold 1200, limits 20 / 10 / 5
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // invalid frames read as all zero
      '{'{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
        '{1'b0, 1'b0, LEVEL_SLOW, 16'sd0, 16'sd0, 16'sd0}},
      '{'{1'b0, 16'd900, 16'd2100, 16'd1800, 16'd2000, 16'd0}, 1'b1,
        '{1'b0, 1'b0, LEVEL_SLOW, 16'sd0, 16'sd0, 16'sd0}},
      // knob just above threshold and at its top: online but disabled
      '{'{1'b1, 16'd900, 16'd2100, 16'd1800, 16'd2000, 16'd1201}, 1'b1,
        '{1'b1, 1'b0, LEVEL_SLOW, 16'sd0, 16'sd0, 16'sd0}},
      '{'{1'b1, 16'd900, 16'd2100, 16'd1800, 16'd2000, 16'd65535}, 1'b1,
        '{1'b1, 1'b0, LEVEL_SLOW, 16'sd0, 16'sd0, 16'sd0}},
      // full deflection at each speed level, knob exactly at threshold in the first
      '{'{1'b1, 16'd900, 16'd2100, 16'd1500, 16'd2000, 16'd1200}, 1'b1,
        '{1'b1, 1'b1, LEVEL_FAST, 16'sd20480, -16'sd20480, 16'sd0}},
      '{'{1'b1, 16'd900, 16'd2100, 16'd1500, 16'd1000, 16'd0}, 1'b1,
        '{1'b1, 1'b1, LEVEL_SLOW, 16'sd5120, -16'sd5120, 16'sd0}},
      '{'{1'b1, 16'd900, 16'd2100, 16'd1500, 16'd1500, 16'd0}, 1'b1,
        '{1'b1, 1'b1, LEVEL_MEDIUM, 16'sd10240, -16'sd10240, 16'sd0}},
      // channels out of range read as zero
      '{'{1'b1, 16'd0, 16'd65535, 16'd899, 16'd2000, 16'd0}, 1'b1,
        '{1'b1, 1'b1, LEVEL_FAST, 16'sd0, 16'sd0, 16'sd0}},
      // just out of range and on the deadband edges, switch on the tolerance edge
      '{'{1'b1, 16'd2101, 16'd1530, 16'd1470, 16'd1750, 16'd0}, 1'b1,
        '{1'b1, 1'b1, LEVEL_FAST, 16'sd0, 16'sd0, 16'sd0}},
      // the rest go through the predictor
      '{'{1'b1, 16'd1531, 16'd1469, 16'd1000, 16'd1749, 16'd0}, 1'b0, '0},
      '{'{1'b1, 16'd1200, 16'd1800, 16'd2000, 16'd1250, 16'd300}, 1'b0, '0},
      '{'{1'b1, 16'd1000, 16'd1999, 16'd1400, 16'd1251, 16'd0}, 1'b0, '0},
      '{'{1'b1, 16'd1100, 16'd1700, 16'd1600, 16'd2250, 16'd0}, 1'b0, '0},
      '{'{1'b1, 16'd1100, 16'd1700, 16'd1600, 16'd2251, 16'd0}, 1'b0, '0},
      '{'{1'b1, 16'd1990, 16'd1010, 16'd1520, 16'd750, 16'd1100}, 1'b0, '0},
      '{'{1'b1, 16'd1990, 16'd1010, 16'd1520, 16'd749, 16'd0}, 1'b0, '0},
      '{'{1'b1, 16'd2100, 16'd900, 16'd1531, 16'd0, 16'd0}, 1'b0, '0},
      '{'{1'b1, 16'd2100, 16'd900, 16'd1469, 16'd65535, 16'd0}, 1'b0, '0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor copy of the registers
   logic [CH_W-1:0]    cfg_center;
   logic [DB_W-1:0]    cfg_deadband;
   logic [DB_W-1:0]    cfg_tolerance;
   logic [CH_W-1:0]    cfg_threshold;
   logic [LIMIT_W-1:0] cfg_fast;
   logic [LIMIT_W-1:0] cfg_medium;
   logic [LIMIT_W-1:0] cfg_slow;

   command_type pending_commands [$];
   int          frames_sent;
   int          mismatches;
   int          stall_cycles;
   bit          tx_gaps_on;
   bit          rx_gaps_on;

   rc_stick_to_velocity_command #(
      .STICK_SPAN         (STICK_SPAN),
      .SPEED_FRACTION_BITS(FRAC_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit switch_near(logic [CH_W-1:0] value, logic [CH_W-1:0] pos);
      int gap;
      gap = (value > pos) ? int'(value) - int'(pos) : int'(pos) - int'(value);
      return gap <= int'(cfg_tolerance);
   endfunction

   // negated speed command of one stick, two's complement at speed width
   function automatic logic [SPEED_W-1:0] stick_command(logic [CH_W-1:0] ch,
                                                        logic [LIMIT_W-1:0] limit);
      int                 offset;
      int                 mag;
      bit                 below;
      logic [SPEED_W-1:0] speed;
      if (ch < CH_MIN || ch > CH_MAX) return '0;
      offset = int'(ch) - int'(cfg_center);
      below  = offset < 0;
      mag    = below ? -offset : offset;
      if (mag <= int'(cfg_deadband)) return '0;
      if (mag > STICK_SPAN) mag = STICK_SPAN;
      mag = ((mag * int'(limit)) << FRAC_BITS) / STICK_SPAN;
      if (mag > SPEED_MAX) mag = SPEED_MAX;
      speed = SPEED_W'(mag);
      // stick below centre gives a positive command
      return below ? speed : -speed;
   endfunction

   function automatic command_type predict_command(frame_type f);
      command_type        cmd;
      logic [LIMIT_W-1:0] limit;
      cmd = '0;
      if (!f.valid) return cmd;
      cmd.online = 1'b1;
      if (f.en > cfg_threshold) return cmd;
      cmd.enabled = 1'b1;
      // fast is tested first, so it wins when both positions are in reach
      if (switch_near(f.sw, SW_FAST_POS)) begin
         cmd.level = LEVEL_FAST;
         limit     = cfg_fast;
      end else if (switch_near(f.sw, SW_SLOW_POS)) begin
         cmd.level = LEVEL_SLOW;
         limit     = cfg_slow;
      end else begin
         cmd.level = LEVEL_MEDIUM;
         limit     = cfg_medium;
      end
      cmd.fwd = stick_command(f.ry, limit);
      cmd.lat = stick_command(f.rx, limit);
      cmd.yaw = stick_command(f.lx, limit);
      return cmd;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_STICK_CENTER:     cfg_center    = value;
         REG_DEADBAND:         cfg_deadband  = value[DB_W-1:0];
         REG_SWITCH_TOLERANCE: cfg_tolerance = value[DB_W-1:0];
         REG_ENABLE_THRESHOLD: cfg_threshold = value;
         REG_FAST_LIMIT:       cfg_fast      = value[LIMIT_W-1:0];
         REG_MEDIUM_LIMIT:     cfg_medium    = value[LIMIT_W-1:0];
         REG_SLOW_LIMIT:       cfg_slow      = value[LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus

   // mostly sticks in their working range, some near centre, some anywhere
   function automatic logic [CH_W-1:0] random_stick();
      int pick;
      int reach;
      pick  = $urandom_range(99);
      reach = int'(cfg_deadband) + 2;
      if (pick < 70) return CH_W'($urandom_range(2120, 880));
      if (pick < 80) return CH_W'(int'(cfg_center) + int'($urandom_range(2 * reach)) - reach);
      return CH_W'($urandom);
   endfunction

   // switch mostly around its three positions, reaching past the tolerance
   function automatic logic [CH_W-1:0] random_switch();
      int pick;
      int reach;
      pick  = $urandom_range(99);
      reach = int'(cfg_tolerance) + 20;
      if (pick < 30) return CH_W'(2000 + int'($urandom_range(2 * reach)) - reach);
      if (pick < 60) return CH_W'(1000 + int'($urandom_range(2 * reach)) - reach);
      if (pick < 85) return CH_W'($urandom_range(1900, 1100));
      return CH_W'($urandom);
   endfunction

   function automatic frame_type random_frame();
      frame_type f;
      if ($urandom_range(99) < 12) begin
         // noise: every field anywhere
         f.valid = 1'($urandom);
         f.ry    = CH_W'($urandom);
         f.rx    = CH_W'($urandom);
         f.lx    = CH_W'($urandom);
         f.sw    = CH_W'($urandom);
         f.en    = CH_W'($urandom);
      end else begin
         f.valid = $urandom_range(99) < 92;
         f.ry    = random_stick();
         f.rx    = random_stick();
         f.lx    = random_stick();
         f.sw    = random_switch();
         f.en    = ($urandom_range(99) < 85) ? CH_W'($urandom_range(cfg_threshold))
                                             : CH_W'($urandom);
      end
      return f;
   endfunction

   // offer one item at the falling edge, hold it until taken, queue the command
   task automatic send_frame(frame_type f, bit typed, command_type want);
      while (tx_gaps_on && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {f.en, f.sw, f.lx, f.rx, f.ry};
      req_tuser  <= f.valid;
      do @(posedge clock); while (!req_tready);
      pending_commands.push_back(typed ? want : predict_command(f));
      frames_sent++;
      @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      apply_register(idx, value);
   endtask

   // register settings per phase: two extreme sets, one fixed set, then random sets
   task automatic program_phase(int phase);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      case (phase)
         1: begin
            write_register(REG_STICK_CENTER, 16'd0);
            write_register(REG_DEADBAND, 16'd0);
            write_register(REG_SWITCH_TOLERANCE, 16'd0);
            write_register(REG_ENABLE_THRESHOLD, 16'hFFFF);
            write_register(REG_FAST_LIMIT, 16'd31);
            write_register(REG_MEDIUM_LIMIT, 16'd31);
            write_register(REG_SLOW_LIMIT, 16'd31);
         end
         2: begin
            // centre to tolerance all ones, rest zero in their kept low bits
            write_register(REG_STICK_CENTER, 16'hFFFF);
            write_register(REG_DEADBAND, 16'hFFFF);
            write_register(REG_SWITCH_TOLERANCE, 16'hFFFF);
            write_register(REG_ENABLE_THRESHOLD, 16'd0);
            write_register(REG_FAST_LIMIT, 16'hFFE0);
            write_register(REG_MEDIUM_LIMIT, 16'd0);
            write_register(REG_SLOW_LIMIT, 16'd0);
            write_register(REG_UNUSED, junk);
         end
         3: begin
            // switch in reach of both positions, small deadband
            write_register(REG_STICK_CENTER, 16'd1500);
            write_register(REG_DEADBAND, 16'd1);
            write_register(REG_SWITCH_TOLERANCE, 16'd1023);
            write_register(REG_ENABLE_THRESHOLD, 16'd1200);
            write_register(REG_FAST_LIMIT, 16'd25);
            write_register(REG_MEDIUM_LIMIT, 16'd15);
            write_register(REG_SLOW_LIMIT, 16'd1);
         end
         default: begin
            write_register(REG_STICK_CENTER, (phase == 5) ? CSR_DATA_W'($urandom)
                                                          : 16'($urandom_range(1700, 1300)));
            write_register(REG_DEADBAND,
                           16'($urandom_range(120)) | (16'($urandom_range(63)) << DB_W));
            write_register(REG_SWITCH_TOLERANCE,
                           16'($urandom_range(700)) | (16'($urandom_range(63)) << DB_W));
            write_register(REG_ENABLE_THRESHOLD, CSR_DATA_W'($urandom));
            write_register(REG_FAST_LIMIT, CSR_DATA_W'($urandom));
            write_register(REG_MEDIUM_LIMIT, CSR_DATA_W'($urandom));
            write_register(REG_SLOW_LIMIT, CSR_DATA_W'($urandom));
            if (phase == 8) write_register(REG_UNUSED, junk);
         end
      endcase
      csr_we <= 1'b0;
   endtask

   // registers change only once every queued command has come out
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_commands.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- main flow

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      tx_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;
      frames_sent = 0;
      mismatches  = 0;
      cfg_center    = RST_STICK_CENTER;
      cfg_deadband  = RST_DEADBAND;
      cfg_tolerance = RST_SWITCH_TOLERANCE;
      cfg_threshold = RST_ENABLE_THRESHOLD;
      cfg_fast      = RST_FAST_LIMIT;
      cfg_medium    = RST_MEDIUM_LIMIT;
      cfg_slow      = RST_SLOW_LIMIT;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows at the reset defaults, then random items
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_frame(DIRECTED_ROWS[i].frame, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      for (int i = 0; i < FIRST_RANDOM; i++)
         send_frame(random_frame(), 1'b0, '0);

      for (int phase = 1; phase < NUM_PHASES; phase++) begin
         wait_for_drain();
         program_phase(phase);
         // one phase runs flat out on both sides
         tx_gaps_on = (phase != QUIET_PHASE);
         rx_gaps_on = (phase != QUIET_PHASE);
         for (int i = 0; i < PHASE_RANDOM; i++)
            send_frame(random_frame(), 1'b0, '0);
      end

      wait_for_drain();
      if (mismatches == 0 && pending_commands.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   // random stalls, plus one long hold-off so the pipe fills and req stalls
   initial begin : receiver
      int  hold_left;
      bit  hold_done;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && frames_sent >= HOLD_AT_FRAME) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(rx_gaps_on && $urandom_range(99) < 16);
         end
      end
   end

   // ---------------------------------------------------------------- checker

   task automatic check_field(string name, logic [SPEED_W-1:0] want, logic [SPEED_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d actual %0d",
                  $time, name, $signed(want), $signed(got));
      end
   endtask

   // rsp_tdata: level [1:0], forward [17:2], lateral [33:18], yaw [49:34]
   // rsp_tuser: online [0], enabled [1]
   always @(posedge clock) begin
      command_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_commands.size() == 0) begin
            mismatches++;
            $display("%0t: command with nothing expected, expected none actual %h / %h",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            want = pending_commands.pop_front();
            check_field("online flag", 16'(want.online), 16'(rsp_tuser[0]));
            check_field("enabled flag", 16'(want.enabled), 16'(rsp_tuser[1]));
            check_field("speed_level", 16'(want.level), 16'(rsp_tdata[1:0]));
            check_field("forward_speed", want.fwd, rsp_tdata[17:2]);
            check_field("lateral_speed", want.lat, rsp_tdata[33:18]);
            check_field("yaw_rate", want.yaw, rsp_tdata[49:34]);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   // ends the run when nothing moves on any port for too long
   initial begin
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
hdl/rcstv_pkg.sv
hdl/rc_stick_to_velocity_command.sv
sim/rc_stick_to_velocity_command_tb.sv
